@@ hdl/hsv_to_rgb_converter_macros.svh @@
// Assertion macros for the HSV to RGB converter, clocked on i_clk and masked in reset.
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// Same-cycle implication.
`define HSV2RGB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HSV2RGB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/hsv2rgb_pkg.sv @@
// Shared constants and types of the HSV to RGB converter.
`default_nettype none

package hsv2rgb_pkg;

    localparam int C_FRAC_BITS     = 12;
    localparam int C_HUE_W         = 15;
    localparam int C_SECTOR_UNITS  = 3840;
    localparam int C_SECTOR_COUNT  = 6;
    localparam int C_SECTOR_HI_DIV = 15;

    typedef enum logic [2:0] {
        SEC_RED_YELLOW   = 3'd0,
        SEC_YELLOW_GREEN = 3'd1,
        SEC_GREEN_CYAN   = 3'd2,
        SEC_CYAN_BLUE    = 3'd3,
        SEC_BLUE_MAGENTA = 3'd4,
        SEC_MAGENTA_RED  = 3'd5
    } t_sector;

endpackage

`default_nettype wire

@@ hdl/hsv2rgb_in_if.sv @@
// Stream interface that carries one HSV pixel with alpha.
`default_nettype none

interface hsv2rgb_in_if import hsv2rgb_pkg::*; #(
    parameter int FRAC_BITS = C_FRAC_BITS
) ();
    logic                 valid;
    logic                 ready;
    logic [C_HUE_W-1:0]   hue;
    logic [FRAC_BITS:0]   saturation;
    logic [FRAC_BITS:0]   brightness;
    logic [FRAC_BITS:0]   alpha_in;

    modport source (output valid, output hue, output saturation, output brightness,
                    output alpha_in, input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    input alpha_in, output ready);
endinterface

`default_nettype wire

@@ hdl/hsv2rgb_out_if.sv @@
// Stream interface that carries one RGB pixel with alpha.
`default_nettype none

interface hsv2rgb_out_if import hsv2rgb_pkg::*; #(
    parameter int FRAC_BITS = C_FRAC_BITS
) ();
    logic               valid;
    logic               ready;
    logic [FRAC_BITS:0] red;
    logic [FRAC_BITS:0] green;
    logic [FRAC_BITS:0] blue;
    logic [FRAC_BITS:0] alpha_out;

    modport source (output valid, output red, output green, output blue,
                    output alpha_out, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input alpha_out, output ready);
endinterface

`default_nettype wire

@@ hdl/hsv_to_rgb_converter.sv @@
// Four-stage pipelined HSV to RGB pixel converter with alpha pass-through.
`default_nettype none
`include "hsv_to_rgb_converter_macros.svh"

// The converter accepts one pixel per clock while its output is not held. Stage one splits
// the hue into a sector and an in-sector remainder and clamps saturation and brightness
// to 1.0, stage two turns the remainder into the fraction f with a reciprocal multiply,
// stage three forms f*s, (1-f)*s and p, and stage four forms q and t and routes the channels
// into the output register. Each stage holds its item while the stage after it is full and
// stalled, so a held output stalls the pipeline back to the input.
module hsv_to_rgb_converter import hsv2rgb_pkg::*; #(
    parameter int FRAC_BITS = C_FRAC_BITS
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    hsv2rgb_in_if.sink    i_pix,
    hsv2rgb_out_if.source o_pix
);

    localparam int FW       = FRAC_BITS + 1;
    localparam int XW       = FRAC_BITS + 4;
    localparam int KSH      = XW + 4;
    localparam int MW       = KSH - 3;
    localparam int PW       = XW + MW;
    localparam logic [FW-1:0] ONE   = FW'(1) << FRAC_BITS;
    localparam logic [MW-1:0] RECIP = MW'(((1 << KSH) + C_SECTOR_HI_DIV - 1) / C_SECTOR_HI_DIV);

    function automatic logic [3:0] hi_quotient(input logic [6:0] hi);
        logic [3:0] q;
        q = '0;
        for (int k = 1; k <= 8; k++) begin
            if (hi >= 7'(C_SECTOR_HI_DIV * k)) begin
                q = q + 4'd1;
            end
        end
        return q;
    endfunction

    function automatic logic [FW-1:0] clamp_one(input logic [FW-1:0] x);
        return (x > ONE) ? ONE : x;
    endfunction

    logic rdy1, rdy2, rdy3, rdy4;

    logic          r_v1, r_v2, r_v3, r_v4;
    t_sector       r_sec1, r_sec2, r_sec3;
    logic [11:0]   r_rem1;
    logic [FW-1:0] r_s1, r_s2, r_v1d, r_v2d, r_v3d;
    logic [FW-1:0] r_a1, r_a2, r_a3;
    logic [FRAC_BITS-1:0] r_f2;
    logic [FRAC_BITS-1:0] r_fs3;
    logic [FW-1:0] r_gs3, r_p3;
    logic [FW-1:0] r_red4, r_green4, r_blue4, r_a4;

    logic [3:0]    n_quo;
    logic [3:0]    n_rem_hi;
    t_sector       n_sec1;
    logic [XW-1:0] n_x;
    logic [PW-1:0] n_fprod;
    logic [FRAC_BITS-1:0] n_f2;
    logic [FW-1:0] n_omf;
    logic [2*FW-1:0] n_fsprod, n_gsprod, n_pprod, n_qprod, n_tprod;
    logic [FW-1:0] n_q, n_t;
    logic [FW-1:0] n_red4, n_green4, n_blue4;

    assign rdy4        = !r_v4 || o_pix.ready;
    assign rdy3        = !r_v3 || rdy4;
    assign rdy2        = !r_v2 || rdy3;
    assign rdy1        = !r_v1 || rdy2;
    assign i_pix.ready = rdy1;

    always_comb begin
        n_quo    = hi_quotient(i_pix.hue[14:8]);
        n_rem_hi = 4'(i_pix.hue[14:8] - 7'(C_SECTOR_HI_DIV) * {3'd0, n_quo});
        if (n_quo >= 4'(C_SECTOR_COUNT)) begin
            n_sec1 = t_sector'(3'(n_quo - 4'(C_SECTOR_COUNT)));
        end else begin
            n_sec1 = t_sector'(n_quo[2:0]);
        end
    end

    always_comb begin
        n_x     = XW'(r_rem1) << (FRAC_BITS - 8);
        n_fprod = PW'(n_x) * PW'(RECIP);
        n_f2    = n_fprod[KSH +: FRAC_BITS];
    end

    always_comb begin
        n_omf    = ONE - FW'(r_f2);
        n_fsprod = (2*FW)'(r_f2) * (2*FW)'(r_s2);
        n_gsprod = (2*FW)'(n_omf) * (2*FW)'(r_s2);
        n_pprod  = (2*FW)'(r_v2d) * (2*FW)'(ONE - r_s2);
    end

    always_comb begin
        n_qprod = (2*FW)'(r_v3d) * (2*FW)'(ONE - FW'(r_fs3));
        n_tprod = (2*FW)'(r_v3d) * (2*FW)'(ONE - r_gs3);
        n_q     = n_qprod[FRAC_BITS +: FW];
        n_t     = n_tprod[FRAC_BITS +: FW];
        case (r_sec3)
            SEC_RED_YELLOW: begin
                n_red4 = r_v3d; n_green4 = n_t;   n_blue4 = r_p3;
            end
            SEC_YELLOW_GREEN: begin
                n_red4 = n_q;   n_green4 = r_v3d; n_blue4 = r_p3;
            end
            SEC_GREEN_CYAN: begin
                n_red4 = r_p3;  n_green4 = r_v3d; n_blue4 = n_t;
            end
            SEC_CYAN_BLUE: begin
                n_red4 = r_p3;  n_green4 = n_q;   n_blue4 = r_v3d;
            end
            SEC_BLUE_MAGENTA: begin
                n_red4 = n_t;   n_green4 = r_p3;  n_blue4 = r_v3d;
            end
            SEC_MAGENTA_RED: begin
                n_red4 = r_v3d; n_green4 = r_p3;  n_blue4 = n_q;
            end
            default: begin
                n_red4 = r_v3d; n_green4 = r_p3;  n_blue4 = n_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_pix.valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_sec1 <= n_sec1;
            r_rem1 <= {n_rem_hi, i_pix.hue[7:0]};
            r_s1   <= clamp_one(i_pix.saturation);
            r_v1d  <= clamp_one(i_pix.brightness);
            r_a1   <= i_pix.alpha_in;
        end
        if (rdy2) begin
            r_sec2 <= r_sec1;
            r_f2   <= n_f2;
            r_s2   <= r_s1;
            r_v2d  <= r_v1d;
            r_a2   <= r_a1;
        end
        if (rdy3) begin
            r_sec3 <= r_sec2;
            r_fs3  <= n_fsprod[FRAC_BITS +: FRAC_BITS];
            r_gs3  <= n_gsprod[FRAC_BITS +: FW];
            r_p3   <= n_pprod[FRAC_BITS +: FW];
            r_v3d  <= r_v2d;
            r_a3   <= r_a2;
        end
        if (rdy4) begin
            r_red4   <= n_red4;
            r_green4 <= n_green4;
            r_blue4  <= n_blue4;
            r_a4     <= r_a3;
        end
    end

    assign o_pix.valid     = r_v4;
    assign o_pix.red       = r_red4;
    assign o_pix.green     = r_green4;
    assign o_pix.blue      = r_blue4;
    assign o_pix.alpha_out = r_a4;

    `HSV2RGB_ASSERT_NOW(a_hue_split, r_v1,
        (r_sec1 <= SEC_MAGENTA_RED) && (r_rem1 < 12'(C_SECTOR_UNITS)),
        "Hue split gave a sector or remainder out of range.")

    `HSV2RGB_ASSERT_NEXT(a_stage3_hold, r_v3 && !rdy4,
        r_v3 && $stable(r_fs3) && $stable(r_gs3) && $stable(r_p3),
        "Stage three item changed while the output was stalled.")

    `HSV2RGB_ASSERT_NOW(a_rgb_range, r_v4,
        (r_red4 <= ONE) && (r_green4 <= ONE) && (r_blue4 <= ONE),
        "A color channel exceeds 1.0.")

endmodule

`default_nettype wire
